// ===== rtl/infix_expression_evaluator_assert.svh =====
// Assertion macro shared by the infix expression evaluator modules.
`ifndef INFIX_EXPRESSION_EVALUATOR_ASSERT_SVH
`define INFIX_EXPRESSION_EVALUATOR_ASSERT_SVH

// Checks an implication-style property on the rising clock edge outside reset.
`define IEVAL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

// ===== rtl/ieval_pkg.sv =====
// Package with operator codes, symbol classes and the command and status types.
package ieval_pkg;

  localparam logic [2:0] OP_ADD    = 3'd0;
  localparam logic [2:0] OP_SUB    = 3'd1;
  localparam logic [2:0] OP_MUL    = 3'd2;
  localparam logic [2:0] OP_DIV    = 3'd3;
  localparam logic [2:0] OP_LPAREN = 3'd4;

  localparam logic [7:0] CH_ADD   = 8'h2B;
  localparam logic [7:0] CH_SUB   = 8'h2D;
  localparam logic [7:0] CH_MUL   = 8'h2A;
  localparam logic [7:0] CH_DIV   = 8'h2F;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [2:0] K_DIGIT = 3'd0;
  localparam logic [2:0] K_LPAR  = 3'd1;
  localparam logic [2:0] K_RPAR  = 3'd2;
  localparam logic [2:0] K_OPER  = 3'd3;
  localparam logic [2:0] K_OTHER = 3'd4;

  typedef struct packed {
    logic latch;
    logic val_push_digit;
    logic val_push_res;
    logic val_pop;
    logic val_peek;
    logic op_push;
    logic op_peek;
    logic op_pop;
    logic cap_r;
    logic cap_l;
    logic exec;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic [2:0] kind;
    logic       fin;
    logic       op_empty;
    logic       top_is_lpar;
    logic       top_ge;
    logic       exec_div;
    logic       div_busy;
    logic       out_busy;
  } stat_t;

  function automatic logic [1:0] prec_of(input logic [2:0] op);
    logic [1:0] p;
    p = 2'd0;
    if (op == OP_ADD || op == OP_SUB) p = 2'd1;
    else if (op == OP_MUL || op == OP_DIV) p = 2'd2;
    return p;
  endfunction

  function automatic logic [2:0] op_of(input logic [7:0] ch);
    logic [2:0] op;
    op = OP_DIV;
    if (ch == CH_ADD) op = OP_ADD;
    else if (ch == CH_SUB) op = OP_SUB;
    else if (ch == CH_MUL) op = OP_MUL;
    return op;
  endfunction

endpackage

// ===== rtl/infix_expression_evaluator.sv =====
// Top level of the infix expression evaluator: controller plus datapath.
// Each item is latched and dispatched; an operator, right parenthesis or finish may then apply
// operators from the stack, each popping two values and pushing its result (a division by a
// nonzero value waits for the divider); a finish drops left parentheses, then loads the result.
// Items are taken one at a time: in_ready is high only while the controller is idle.
// Synchronous reset empties both stacks, clears the overflow flag and drops a pending result.
module infix_expression_evaluator #(
  parameter int STACK_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        symbol,
  input  logic              finish,
  output logic              out_valid,
  input  logic              out_ready,
  output logic signed [7:0] value,
  output logic              divide_by_zero,
  output logic              stack_overflow
);

  ieval_pkg::cmd_t  cmd;
  ieval_pkg::stat_t stat;

  ieval_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ieval_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .symbol         (symbol),
    .finish         (finish),
    .cmd            (cmd),
    .stat           (stat),
    .value          (value),
    .divide_by_zero (divide_by_zero),
    .stack_overflow (stack_overflow),
    .out_valid      (out_valid),
    .out_ready      (out_ready)
  );

endmodule

// ===== rtl/ieval_dp.sv =====
// Datapath: input latch, operator and value stacks, ALU, divider and result register.
module ieval_dp #(
  parameter int STACK_DEPTH = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic [7:0]     symbol,
  input  logic           finish,
  input  ieval_pkg::cmd_t cmd,
  output ieval_pkg::stat_t stat,
  output logic signed [7:0] value,
  output logic           divide_by_zero,
  output logic           stack_overflow,
  output logic           out_valid,
  input  logic           out_ready
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

  logic [7:0]    sym_q;
  logic          fin_q;
  logic [2:0]    omem [STACK_DEPTH];
  logic [8:0]    vmem [STACK_DEPTH];
  logic [CW-1:0] ocnt;
  logic [CW-1:0] vcnt;
  logic [CW-1:0] ocnt_dec;
  logic [CW-1:0] vcnt_dec;
  logic          ovf;
  logic [2:0]    op_q;
  logic [8:0]    vq;
  logic          vq_zero;
  logic [8:0]    vrd;
  logic [8:0]    r_q;
  logic [8:0]    l_q;
  logic [8:0]    res_q;
  logic          use_div;
  logic [3:0]    div_cnt;
  logic [7:0]    rem;
  logic [7:0]    quo;
  logic [7:0]    dvs;
  logic          neg;
  logic          div_mark;
  logic [8:0]    rem_sh;
  logic [7:0]    a_mag;
  logic [7:0]    b_mag;
  logic signed [7:0] a_s;
  logic signed [7:0] b_s;
  logic [15:0]   prod;
  logic [7:0]    q_signed;
  logic [8:0]    push_res;
  logic [8:0]    digit_val;
  logic [2:0]    kind;
  logic [2:0]    push_code;

  assign ocnt_dec = ocnt - CW'(1);
  assign vcnt_dec = vcnt - CW'(1);
  assign vrd      = vq_zero ? 9'd0 : vq;
  assign a_s      = l_q[7:0];
  assign b_s      = r_q[7:0];
  assign a_mag    = a_s[7] ? 8'(-a_s) : 8'(a_s);
  assign b_mag    = b_s[7] ? 8'(-b_s) : 8'(b_s);
  assign prod     = 16'(a_s * b_s);
  assign rem_sh   = {rem, quo[7]};
  assign q_signed = neg ? 8'(-quo) : quo;
  assign push_res = use_div ? {div_mark, q_signed} : res_q;
  assign digit_val = {1'b0, sym_q - ieval_pkg::CH_ZERO};
  assign push_code = (kind == ieval_pkg::K_LPAR) ? ieval_pkg::OP_LPAREN
                                                 : ieval_pkg::op_of(sym_q);

  always_comb begin
    if (sym_q >= ieval_pkg::CH_ZERO && sym_q <= ieval_pkg::CH_NINE) begin
      kind = ieval_pkg::K_DIGIT;
    end else if (sym_q == ieval_pkg::CH_LPAR) begin
      kind = ieval_pkg::K_LPAR;
    end else if (sym_q == ieval_pkg::CH_RPAR) begin
      kind = ieval_pkg::K_RPAR;
    end else if (sym_q == ieval_pkg::CH_ADD || sym_q == ieval_pkg::CH_SUB ||
                 sym_q == ieval_pkg::CH_MUL || sym_q == ieval_pkg::CH_DIV) begin
      kind = ieval_pkg::K_OPER;
    end else begin
      kind = ieval_pkg::K_OTHER;
    end
  end

  always_comb begin
    stat.kind        = kind;
    stat.fin         = fin_q;
    stat.op_empty    = (ocnt == '0);
    stat.top_is_lpar = (op_q == ieval_pkg::OP_LPAREN);
    stat.top_ge      = ieval_pkg::prec_of(op_q) >= ieval_pkg::prec_of(ieval_pkg::op_of(sym_q));
    stat.exec_div    = (op_q == ieval_pkg::OP_DIV) && (r_q[7:0] != 8'd0);
    stat.div_busy    = (div_cnt != 4'd0);
    stat.out_busy    = out_valid && !out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      sym_q <= symbol;
      fin_q <= finish;
    end
    if (cmd.op_push && ocnt < DEPTH_C) begin
      omem[ocnt[AW-1:0]] <= push_code;
    end
    if (cmd.op_peek) begin
      op_q <= omem[ocnt_dec[AW-1:0]];
    end
    if (cmd.val_push_digit && vcnt < DEPTH_C) begin
      vmem[vcnt[AW-1:0]] <= digit_val;
    end else if (cmd.val_push_res && vcnt < DEPTH_C) begin
      vmem[vcnt[AW-1:0]] <= push_res;
    end
    if (cmd.val_pop || cmd.val_peek) begin
      vq      <= vmem[vcnt_dec[AW-1:0]];
      vq_zero <= (vcnt == '0);
    end
    if (cmd.cap_r) r_q <= vrd;
    if (cmd.cap_l) l_q <= vrd;
    if (cmd.exec) begin
      use_div <= 1'b0;
      unique case (op_q)
        ieval_pkg::OP_ADD: res_q <= {l_q[8] | r_q[8], 8'(a_s + b_s)};
        ieval_pkg::OP_SUB: res_q <= {l_q[8] | r_q[8], 8'(a_s - b_s)};
        ieval_pkg::OP_MUL: res_q <= {l_q[8] | r_q[8], prod[7:0]};
        default: begin
          if (r_q[7:0] == 8'd0) begin
            res_q <= 9'h100;
          end else begin
            use_div  <= 1'b1;
            rem      <= 8'd0;
            quo      <= a_mag;
            dvs      <= b_mag;
            neg      <= a_s[7] ^ b_s[7];
            div_mark <= l_q[8] | r_q[8];
          end
        end
      endcase
    end else if (div_cnt != 4'd0) begin
      if (rem_sh >= {1'b0, dvs}) begin
        rem <= 8'(rem_sh - {1'b0, dvs});
        quo <= {quo[6:0], 1'b1};
      end else begin
        rem <= rem_sh[7:0];
        quo <= {quo[6:0], 1'b0};
      end
    end
    if (cmd.load_out) begin
      value          <= vrd[7:0];
      divide_by_zero <= vrd[8];
      stack_overflow <= ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ocnt      <= '0;
      vcnt      <= '0;
      ovf       <= 1'b0;
      div_cnt   <= 4'd0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.exec && op_q == ieval_pkg::OP_DIV && r_q[7:0] != 8'd0) begin
        div_cnt <= 4'd8;
      end else if (div_cnt != 4'd0) begin
        div_cnt <= div_cnt - 4'd1;
      end
      if (cmd.op_push) begin
        if (ocnt < DEPTH_C) ocnt <= ocnt + CW'(1);
        else ovf <= 1'b1;
      end else if (cmd.op_pop && ocnt != '0) begin
        ocnt <= ocnt_dec;
      end
      if (cmd.val_push_digit || cmd.val_push_res) begin
        if (vcnt < DEPTH_C) vcnt <= vcnt + CW'(1);
        else ovf <= 1'b1;
      end else if (cmd.val_pop && vcnt != '0) begin
        vcnt <= vcnt_dec;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
        ocnt      <= '0;
        vcnt      <= '0;
        ovf       <= 1'b0;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`include "infix_expression_evaluator_assert.svh"

  `IEVAL_ASSERT(a_vcnt_bound, vcnt <= DEPTH_C, "value count beyond depth")
  `IEVAL_ASSERT(a_ocnt_bound, ocnt <= DEPTH_C, "operator count beyond depth")
  `IEVAL_ASSERT(a_load_valid, cmd.load_out |=> out_valid && ocnt == '0 && vcnt == '0, "result load did not present the item")
  `IEVAL_ASSERT(a_div_start, (cmd.exec && op_q == ieval_pkg::OP_DIV && r_q[7:0] != 8'd0) |=> div_cnt == 4'd8, "divider did not start")

endmodule

// ===== rtl/ieval_ctrl.sv =====
// Controller state machine sequencing the shunting-yard steps over the datapath.
module ieval_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  ieval_pkg::stat_t stat,
  output ieval_pkg::cmd_t  cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_OPCHK = 4'd2;
  localparam logic [3:0] S_POPR  = 4'd3;
  localparam logic [3:0] S_POPL  = 4'd4;
  localparam logic [3:0] S_CAPL  = 4'd5;
  localparam logic [3:0] S_EXEC  = 4'd6;
  localparam logic [3:0] S_DIVW  = 4'd7;
  localparam logic [3:0] S_PUSH  = 4'd8;
  localparam logic [3:0] S_RES   = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        if (stat.fin) begin
          if (stat.op_empty) begin
            cmd.val_peek = 1'b1;
            state_next   = S_RES;
          end else begin
            cmd.op_peek = 1'b1;
            state_next  = S_OPCHK;
          end
        end else begin
          unique case (stat.kind)
            ieval_pkg::K_DIGIT: begin
              cmd.val_push_digit = 1'b1;
              state_next         = S_IDLE;
            end
            ieval_pkg::K_LPAR: begin
              cmd.op_push = 1'b1;
              state_next  = S_IDLE;
            end
            ieval_pkg::K_RPAR, ieval_pkg::K_OPER: begin
              if (stat.op_empty) begin
                cmd.op_push = (stat.kind == ieval_pkg::K_OPER);
                state_next  = S_IDLE;
              end else begin
                cmd.op_peek = 1'b1;
                state_next  = S_OPCHK;
              end
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_OPCHK: begin
        if (stat.fin) begin
          cmd.op_pop = 1'b1;
          state_next = stat.top_is_lpar ? S_DISP : S_POPR;
        end else if (stat.kind == ieval_pkg::K_RPAR) begin
          cmd.op_pop = 1'b1;
          state_next = stat.top_is_lpar ? S_IDLE : S_POPR;
        end else if (stat.top_ge) begin
          cmd.op_pop = 1'b1;
          state_next = S_POPR;
        end else begin
          cmd.op_push = 1'b1;
          state_next  = S_IDLE;
        end
      end
      S_POPR: begin
        cmd.val_pop = 1'b1;
        state_next  = S_POPL;
      end
      S_POPL: begin
        cmd.cap_r   = 1'b1;
        cmd.val_pop = 1'b1;
        state_next  = S_CAPL;
      end
      S_CAPL: begin
        cmd.cap_l  = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = stat.exec_div ? S_DIVW : S_PUSH;
      end
      S_DIVW: begin
        if (!stat.div_busy) state_next = S_PUSH;
      end
      S_PUSH: begin
        cmd.val_push_res = 1'b1;
        state_next       = S_DISP;
      end
      S_RES: begin
        if (!stat.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

`include "infix_expression_evaluator_assert.svh"

  `IEVAL_ASSERT(a_accept_idle, (in_valid && in_ready) |=> state == S_DISP, "accepted item not dispatched")
  `IEVAL_ASSERT(a_div_wait, (state == S_EXEC && stat.exec_div) |=> state == S_DIVW, "division not awaited")
  `IEVAL_ASSERT(a_load_res, cmd.load_out |-> state == S_RES && !stat.out_busy, "result loaded outside result step")

endmodule
